// ----- hw/rtl/pcocs_pkg.sv -----
`timescale 1ns / 1ps

package pcocs_pkg;

    // converter resolution; samples are taken in their low ADC_BITS bits
    localparam int ADC_BITS = 12;

    // fixed field widths
    localparam int RAW_W   = 12;
    localparam int GAIN_W  = 16;
    localparam int CNT_W   = 16;
    localparam int SUM_W   = 28;
    localparam int CUR_W   = 21;
    localparam int FAULT_W = 3;
    localparam int DIFF_W  = RAW_W + 1;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int QUO_W   = PROD_W - 8;
    localparam int NPHASE  = 3;
    localparam int PH_W    = 2;
    localparam int DCNT_W  = $clog2(SUM_W);

    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 72;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 16;

    // sample mask for the low ADC_BITS bits of a RAW_W wide sample
    localparam logic [RAW_W-1:0] ADC_MASK = RAW_W'((64'd1 << ADC_BITS) - 64'd1);

    // register indexes on the configuration port
    localparam logic [CFG_A_W-1:0] REG_DEFAULT_OFFSET  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_FAULT_TOLERANCE = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_CAL_SAMPLES     = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_AMP_GAIN        = 2'd3;

    // reset values
    localparam logic [RAW_W-1:0]  RST_DEFAULT_OFFSET  = 12'd2048;
    localparam logic [RAW_W-1:0]  RST_FAULT_TOLERANCE = 12'd200;
    localparam logic [CNT_W-1:0]  RST_CAL_SAMPLES     = 16'd64;
    localparam logic [GAIN_W-1:0] RST_AMP_GAIN        = 16'd256;

    // action codes
    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_POLL    = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quot;
    } div_res_t;

endpackage

// ----- hw/rtl/pcocs_mul.sv -----
`timescale 1ns / 1ps

module pcocs_mul (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic [pcocs_pkg::RAW_W-1:0]           sample,
    input  logic [pcocs_pkg::RAW_W-1:0]           offset,
    input  logic [pcocs_pkg::GAIN_W-1:0]          gain,
    output logic signed [pcocs_pkg::PROD_W-1:0]   prod
);

    logic signed [pcocs_pkg::DIFF_W-1:0]   diff;
    logic signed [pcocs_pkg::GAIN_W:0]     gain_s;
    logic signed [pcocs_pkg::PROD_W-1:0]   prod_reg;

    // signed difference from the offset, gain as a positive operand
    assign diff   = $signed({1'b0, sample}) - $signed({1'b0, offset});
    assign gain_s = $signed({1'b0, gain});

    // registered product
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= diff * gain_s;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- hw/rtl/pcocs_div.sv -----
`timescale 1ns / 1ps

module pcocs_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pcocs_pkg::SUM_W-1:0]   dividend,
    input  logic [pcocs_pkg::CNT_W-1:0]   divisor,
    output pcocs_pkg::div_res_t           res
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [pcocs_pkg::DCNT_W-1:0]  cnt_reg;
    logic [pcocs_pkg::CNT_W-1:0]   rem_reg;
    logic [pcocs_pkg::CNT_W-1:0]   dvs_reg;
    logic [pcocs_pkg::SUM_W-1:0]   quot_reg;
    logic [pcocs_pkg::CNT_W:0]     trial;
    logic [pcocs_pkg::CNT_W:0]     diff;
    logic                          qbit;

    // one restoring step: shift in the next dividend bit and try to subtract
    assign trial = {rem_reg, quot_reg[pcocs_pkg::SUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = ~diff[pcocs_pkg::CNT_W];

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == pcocs_pkg::DCNT_W'(pcocs_pkg::SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // quotient bits shift in where dividend bits shift out
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            quot_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg  <= qbit ? diff[pcocs_pkg::CNT_W-1:0] : trial[pcocs_pkg::CNT_W-1:0];
            quot_reg <= {quot_reg[pcocs_pkg::SUM_W-2:0], qbit};
        end
    end

    assign res.busy = busy_reg;
    assign res.done = done_reg;
    assign res.quot = quot_reg;

    // the remainder always stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start |-> rem_reg < dvs_reg || dvs_reg == '0)
        else $error("divider remainder not below divisor");

    // a finish pulse follows a full run of steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider finished without running");

    // the divider is not restarted while it runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("divider restarted while busy");

endmodule

// ----- hw/rtl/phase_current_offset_calibrate_scale_core.sv -----
`timescale 1ns / 1ps

// Three-phase shunt current front end with offset calibration.
// Input words arrive on the s_ channel: s_tdata holds the three ADC samples,
// s_tuser holds the action (measure or calibration poll) and the poll's
// conversion-ok flag. Every input word gives exactly one output word on the
// m_ channel: three phase currents in mA, the fault mask and a run-done flag.
// Configuration registers are written through cfg_wr_en / cfg_addr /
// cfg_wdata; the user must write them only while the block is idle, which
// the block itself does not enforce. A measure word runs the three phases
// through one shared multiplier, one phase per cycle; its result is loaded
// into the output register from the DONE state once that register is free.
// The poll that ends a run with valid samples runs the three offsets through
// one shared 28-step restoring divider, one phase after another.
// s_tready is high only while no word is being worked on; one more word can
// be accepted while a finished result still waits in the output register,
// and its result is held back until m_tready takes the earlier one.
// Reset (aresetn low, synchronous) restores the register defaults, sets all
// offsets to 2048, clears sums, counters and fault bits, and empties the
// output register.

module phase_current_offset_calibrate_scale_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // raw_a [11:0], raw_b [23:12], raw_c [35:24], zero fill [39:36]
    input  logic [pcocs_pkg::S_DATA_W-1:0]      s_tdata,
    // action [0], sample_ok [1]
    input  logic [pcocs_pkg::S_USER_W-1:0]      s_tuser,
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // current_a [20:0], current_b [41:21], current_c [62:42],
    // fault_mask [65:63], cal_done [66], zero fill [71:67]
    output logic [pcocs_pkg::M_DATA_W-1:0]      m_tdata,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [pcocs_pkg::CFG_A_W-1:0]       cfg_addr,
    input  logic [pcocs_pkg::CFG_D_W-1:0]       cfg_wdata
);

    localparam int RAW_W  = pcocs_pkg::RAW_W;
    localparam int CNT_W  = pcocs_pkg::CNT_W;
    localparam int SUM_W  = pcocs_pkg::SUM_W;
    localparam int CUR_W  = pcocs_pkg::CUR_W;
    localparam int QUO_W  = pcocs_pkg::QUO_W;
    localparam int NPHASE = pcocs_pkg::NPHASE;
    localparam int PH_W   = pcocs_pkg::PH_W;

    // configuration registers
    logic [RAW_W-1:0]            default_offset_reg;
    logic [RAW_W-1:0]            fault_tolerance_reg;
    logic [CNT_W-1:0]            cal_samples_reg;
    logic [pcocs_pkg::GAIN_W-1:0] amp_gain_reg;

    // calibration state
    logic [RAW_W-1:0]            offset_reg [NPHASE];
    logic [SUM_W-1:0]            sum_reg [NPHASE];
    logic [CNT_W-1:0]            poll_count_reg;
    logic [CNT_W-1:0]            valid_count_reg;
    logic [pcocs_pkg::FAULT_W-1:0] fault_bits_reg;

    // sequencer and item registers
    pcocs_pkg::state_t           state_reg, state_next;
    logic [PH_W-1:0]             ph_reg;
    logic                        act_reg;
    logic                        ok_reg;
    logic [RAW_W-1:0]            raw_reg [NPHASE];
    logic [CUR_W-1:0]            cur_reg [NPHASE];
    logic                        done_flag_reg;
    logic                        div_start_reg;

    // output register
    logic                        m_valid_reg;
    logic [pcocs_pkg::M_DATA_W-1:0] m_data_reg;

    // shared units
    logic                        mul_en;
    logic signed [pcocs_pkg::PROD_W-1:0] prod;
    pcocs_pkg::div_res_t         div_res;

    logic                        in_fire;
    logic                        out_free;
    logic [PH_W-1:0]             ph_prev;
    logic signed [QUO_W-1:0]     quo;
    logic [CUR_W-1:0]            cur_sat;
    logic [CNT_W-1:0]            target;
    logic [CNT_W-1:0]            poll_next;
    logic [CNT_W-1:0]            valid_next;
    logic                        run_end;
    logic [SUM_W:0]              fresh_w;
    logic [SUM_W:0]              upper_w;
    logic [SUM_W:0]              lower_w;
    logic                        out_of_tol;
    logic [CUR_W-1:0]            cur_out [NPHASE];

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == pcocs_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_offset_reg  <= pcocs_pkg::RST_DEFAULT_OFFSET;
            fault_tolerance_reg <= pcocs_pkg::RST_FAULT_TOLERANCE;
            cal_samples_reg     <= pcocs_pkg::RST_CAL_SAMPLES;
            amp_gain_reg        <= pcocs_pkg::RST_AMP_GAIN;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                pcocs_pkg::REG_DEFAULT_OFFSET:  default_offset_reg  <= cfg_wdata[RAW_W-1:0];
                pcocs_pkg::REG_FAULT_TOLERANCE: fault_tolerance_reg <= cfg_wdata[RAW_W-1:0];
                pcocs_pkg::REG_CAL_SAMPLES:     cal_samples_reg     <= cfg_wdata;
                pcocs_pkg::REG_AMP_GAIN:        amp_gain_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // shared multiplier, one phase per cycle
    assign mul_en = (state_reg == pcocs_pkg::ST_MUL) && (ph_reg != PH_W'(NPHASE));

    pcocs_mul u_mul (
        .aclk   (aclk),
        .en     (mul_en),
        .sample (raw_reg[ph_reg]),
        .offset (offset_reg[ph_reg]),
        .gain   (amp_gain_reg),
        .prod   (prod)
    );

    // floor by 256 and saturate to the current range
    assign quo = prod[pcocs_pkg::PROD_W-1:8];
    always_comb begin
        if (quo[QUO_W-1] != quo[CUR_W-1]) begin
            cur_sat = {quo[QUO_W-1], {(CUR_W-1){~quo[QUO_W-1]}}};
        end else begin
            cur_sat = quo[CUR_W-1:0];
        end
    end
    assign ph_prev = ph_reg - 1'b1;

    // shared divider for the end-of-run offsets
    pcocs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (sum_reg[ph_reg]),
        .divisor  (valid_count_reg),
        .res      (div_res)
    );

    // poll bookkeeping
    assign target     = (cal_samples_reg == '0) ? CNT_W'(1) : cal_samples_reg;
    assign poll_next  = poll_count_reg + 1'b1;
    assign valid_next = ok_reg ? valid_count_reg + 1'b1 : valid_count_reg;
    assign run_end    = (poll_next >= target);

    // tolerance window around the default offset
    assign fresh_w    = {1'b0, div_res.quot};
    assign upper_w    = (SUM_W + 1)'(default_offset_reg) + (SUM_W + 1)'(fault_tolerance_reg);
    assign lower_w    = fresh_w + (SUM_W + 1)'(fault_tolerance_reg);
    assign out_of_tol = (fresh_w > upper_w) ||
                        (lower_w < (SUM_W + 1)'(default_offset_reg));

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pcocs_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = (s_tuser[0] == pcocs_pkg::ACT_POLL) ?
                                 pcocs_pkg::ST_UPD : pcocs_pkg::ST_MUL;
                end
            end
            pcocs_pkg::ST_MUL: begin
                if (ph_reg == PH_W'(NPHASE)) begin
                    state_next = pcocs_pkg::ST_DONE;
                end
            end
            pcocs_pkg::ST_UPD: begin
                if (run_end && valid_next != '0) begin
                    state_next = pcocs_pkg::ST_DIV;
                end else begin
                    state_next = pcocs_pkg::ST_DONE;
                end
            end
            pcocs_pkg::ST_DIV: begin
                if (div_res.done && ph_reg == PH_W'(NPHASE - 1)) begin
                    state_next = pcocs_pkg::ST_DONE;
                end
            end
            pcocs_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = pcocs_pkg::ST_IDLE;
                end
            end
            default: state_next = pcocs_pkg::ST_IDLE;
        endcase
    end

    // control registers and calibration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= pcocs_pkg::ST_IDLE;
            ph_reg          <= '0;
            div_start_reg   <= 1'b0;
            done_flag_reg   <= 1'b0;
            poll_count_reg  <= '0;
            valid_count_reg <= '0;
            fault_bits_reg  <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < NPHASE; i++) begin
                offset_reg[i] <= pcocs_pkg::RST_DEFAULT_OFFSET & pcocs_pkg::ADC_MASK;
                sum_reg[i]    <= '0;
            end
        end else begin
            state_reg     <= state_next;
            div_start_reg <= 1'b0;
            // output valid: load a finished word, or drop the one taken
            if (state_reg == pcocs_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                pcocs_pkg::ST_IDLE: begin
                    ph_reg        <= '0;
                    done_flag_reg <= 1'b0;
                end
                pcocs_pkg::ST_MUL: begin
                    ph_reg <= ph_reg + 1'b1;
                end
                pcocs_pkg::ST_UPD: begin
                    ph_reg <= '0;
                    if (run_end) begin
                        done_flag_reg <= (valid_next == '0);
                    end
                    if (run_end && valid_next == '0) begin
                        poll_count_reg  <= '0;
                        valid_count_reg <= '0;
                        for (int i = 0; i < NPHASE; i++) begin
                            sum_reg[i] <= '0;
                        end
                    end else begin
                        poll_count_reg  <= poll_next;
                        valid_count_reg <= valid_next;
                        if (ok_reg) begin
                            for (int i = 0; i < NPHASE; i++) begin
                                sum_reg[i] <= sum_reg[i] + SUM_W'(raw_reg[i]);
                            end
                        end
                        div_start_reg <= run_end;
                    end
                end
                pcocs_pkg::ST_DIV: begin
                    if (div_res.done) begin
                        fault_bits_reg[ph_reg] <= out_of_tol;
                        if (!out_of_tol) begin
                            offset_reg[ph_reg] <= div_res.quot[RAW_W-1:0] & pcocs_pkg::ADC_MASK;
                        end
                        if (ph_reg == PH_W'(NPHASE - 1)) begin
                            done_flag_reg   <= 1'b1;
                            poll_count_reg  <= '0;
                            valid_count_reg <= '0;
                            for (int i = 0; i < NPHASE; i++) begin
                                sum_reg[i] <= '0;
                            end
                        end else begin
                            ph_reg        <= ph_reg + 1'b1;
                            div_start_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // item capture and measured currents
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            act_reg    <= s_tuser[0];
            ok_reg     <= s_tuser[1];
            raw_reg[0] <= s_tdata[RAW_W-1:0] & pcocs_pkg::ADC_MASK;
            raw_reg[1] <= s_tdata[2*RAW_W-1:RAW_W] & pcocs_pkg::ADC_MASK;
            raw_reg[2] <= s_tdata[3*RAW_W-1:2*RAW_W] & pcocs_pkg::ADC_MASK;
        end
        if (state_reg == pcocs_pkg::ST_MUL && ph_reg != '0) begin
            cur_reg[ph_prev] <= cur_sat;
        end
    end

    // output word; currents read zero on polls
    always_comb begin
        for (int i = 0; i < NPHASE; i++) begin
            cur_out[i] = (act_reg == pcocs_pkg::ACT_POLL) ? '0 : cur_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == pcocs_pkg::ST_DONE && out_free) begin
            m_data_reg <= pcocs_pkg::M_DATA_W'({done_flag_reg, fault_bits_reg,
                                                cur_out[2], cur_out[1], cur_out[0]});
        end
    end

    // a word with cal_done set carries zero currents
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[3*CUR_W+pcocs_pkg::FAULT_W] |-> m_data_reg[3*CUR_W-1:0] == '0)
        else $error("run-done word with nonzero currents");

    // the divider is started only while offsets are being computed
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> state_reg == pcocs_pkg::ST_DIV)
        else $error("divider start outside offset computation");

    // offsets are computed only with a nonzero valid count
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pcocs_pkg::ST_DIV |-> valid_count_reg != '0)
        else $error("offset division with zero valid polls");

    // an accepted word blocks the input until its result is out
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("input ready right after acceptance");

    // the output register is loaded only when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> $stable(m_data_reg))
        else $error("pending result overwritten");

endmodule

// ----- bench/phase_current_checker.sv -----
`timescale 1ns / 1ps

module phase_current_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // raw_a, raw_b, raw_c, zero fill
    input  logic [pcocs_pkg::S_DATA_W-1:0] s_tdata,
    // action, sample_ok
    input  logic [pcocs_pkg::S_USER_W-1:0] s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // current_a, current_b, current_c, fault_mask, cal_done, zero fill
    input  logic [pcocs_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [pcocs_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [pcocs_pkg::CFG_D_W-1:0]  cfg_wdata,
    output int                             fail_count,
    output int                             pending,
    output int                             words_checked,
    output int                             runs_closed
);
    import pcocs_pkg::*;

    localparam longint AMPS_MAX = (64'sd1 <<< (CUR_W - 1)) - 1;
    localparam longint AMPS_MIN = -AMPS_MAX - 1;

    typedef struct packed {
        logic [CUR_W-1:0]   amps_a;
        logic [CUR_W-1:0]   amps_b;
        logic [CUR_W-1:0]   amps_c;
        logic [FAULT_W-1:0] fault;
        logic               done;
    } reading_t;

    // register copies
    logic [RAW_W-1:0]   nominal_ofs;
    logic [RAW_W-1:0]   tolerance;
    logic [CNT_W-1:0]   run_length;
    logic [GAIN_W-1:0]  gain;

    // calibration state
    logic [RAW_W-1:0]   zero_code [NPHASE];
    logic [SUM_W-1:0]   code_sum [NPHASE];
    logic [CNT_W-1:0]   poll_total;
    logic [CNT_W-1:0]   good_total;
    logic [FAULT_W-1:0] flagged;

    reading_t readings [$];
    reading_t want;
    reading_t got;
    int       fails;
    int       seen;
    int       closed;

    task automatic clear_front_end();
        int ph;
        nominal_ofs = RST_DEFAULT_OFFSET;
        tolerance   = RST_FAULT_TOLERANCE;
        run_length  = RST_CAL_SAMPLES;
        gain        = RST_AMP_GAIN;
        for (ph = 0; ph < NPHASE; ph++) begin
            zero_code[ph] = RST_DEFAULT_OFFSET & ADC_MASK;
            code_sum[ph]  = '0;
        end
        poll_total = '0;
        good_total = '0;
        flagged    = '0;
    endtask

    // (raw - zero) * gain, floored by the q8.8 shift, clipped to the output range
    function automatic logic [CUR_W-1:0] to_milliamps(input logic [RAW_W-1:0] raw,
                                                      input logic [RAW_W-1:0] zero);
        longint prod;
        longint amps;
        prod = (longint'(raw) - longint'(zero)) * longint'(gain);
        amps = prod >>> 8;
        if (amps > AMPS_MAX)
            amps = AMPS_MAX;
        else if (amps < AMPS_MIN)
            amps = AMPS_MIN;
        return amps[CUR_W-1:0];
    endfunction

    // end of a calibration run: average, tolerance check, clear counters
    task automatic close_run();
        logic [SUM_W-1:0] fresh;
        longint           dev;
        int               ph;
        if (good_total != '0) begin
            flagged = '0;
            for (ph = 0; ph < NPHASE; ph++) begin
                fresh = code_sum[ph] / SUM_W'(good_total);
                dev = longint'(fresh) - longint'(nominal_ofs);
                if (dev > longint'(tolerance) || dev < -longint'(tolerance))
                    flagged[ph] = 1'b1;
                else
                    zero_code[ph] = fresh[RAW_W-1:0] & ADC_MASK;
            end
        end
        for (ph = 0; ph < NPHASE; ph++)
            code_sum[ph] = '0;
        poll_total = '0;
        good_total = '0;
    endtask

    task automatic advance_front_end(input logic act, input logic ok,
                                     input logic [S_DATA_W-1:0] data,
                                     output reading_t r);
        logic [RAW_W-1:0] raw [NPHASE];
        logic [CNT_W-1:0] target;
        int               ph;
        raw[0] = data[RAW_W-1:0] & ADC_MASK;
        raw[1] = data[2*RAW_W-1:RAW_W] & ADC_MASK;
        raw[2] = data[3*RAW_W-1:2*RAW_W] & ADC_MASK;
        r = '0;
        if (act == ACT_MEASURE) begin
            r.amps_a = to_milliamps(raw[0], zero_code[0]);
            r.amps_b = to_milliamps(raw[1], zero_code[1]);
            r.amps_c = to_milliamps(raw[2], zero_code[2]);
        end else begin
            target = (run_length == '0) ? CNT_W'(1) : run_length;
            poll_total = poll_total + 1'b1;
            if (ok) begin
                for (ph = 0; ph < NPHASE; ph++)
                    code_sum[ph] = code_sum[ph] + SUM_W'(raw[ph]);
                good_total = good_total + 1'b1;
            end
            // lowered target mid-run also ends the run
            if (poll_total >= target) begin
                close_run();
                r.done = 1'b1;
            end
        end
        r.fault = flagged;
    endtask

    // watch config writes, accepted inputs and accepted results
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_front_end();
            readings.delete();
            fails  = 0;
            seen   = 0;
            closed = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_DEFAULT_OFFSET:  nominal_ofs = cfg_wdata[RAW_W-1:0];
                    REG_FAULT_TOLERANCE: tolerance   = cfg_wdata[RAW_W-1:0];
                    REG_CAL_SAMPLES:     run_length  = cfg_wdata[CNT_W-1:0];
                    REG_AMP_GAIN:        gain        = cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_front_end(s_tuser[0], s_tuser[1], s_tdata, want);
                readings.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.amps_a = m_tdata[CUR_W-1:0];
                got.amps_b = m_tdata[2*CUR_W-1:CUR_W];
                got.amps_c = m_tdata[3*CUR_W-1:2*CUR_W];
                got.fault  = m_tdata[3*CUR_W+FAULT_W-1:3*CUR_W];
                got.done   = m_tdata[3*CUR_W+FAULT_W];
                if (readings.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("result word %0d arrived with nothing outstanding: %h",
                                 seen, m_tdata);
                end else begin
                    want = readings.pop_front();
                    if (want.done)
                        closed++;
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display({"result word %0d mismatch: expected a=%0d b=%0d c=%0d ",
                                      "fault=%b done=%b, got a=%0d b=%0d c=%0d fault=%b done=%b"},
                                     seen, $signed(want.amps_a), $signed(want.amps_b),
                                     $signed(want.amps_c), want.fault, want.done,
                                     $signed(got.amps_a), $signed(got.amps_b),
                                     $signed(got.amps_c), got.fault, got.done);
                    end
                end
                seen++;
            end
        end
        fail_count    <= fails;
        pending       <= readings.size();
        words_checked <= seen;
        runs_closed   <= closed;
    end

endmodule

// ----- bench/phase_current_offset_calibrate_scale_core_test.sv -----
`timescale 1ns / 1ps

module phase_current_offset_calibrate_scale_core_test;
    import pcocs_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    // raw_a [11:0], raw_b [23:12], raw_c [35:24], zero fill [39:36]
    logic [S_DATA_W-1:0] s_tdata;
    // action [0], sample_ok [1]
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // current_a [20:0], current_b [41:21], current_c [62:42],
    // fault_mask [65:63], cal_done [66], zero fill [71:67]
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_wr_en;
    logic [CFG_A_W-1:0]  cfg_addr;
    logic [CFG_D_W-1:0]  cfg_wdata;

    int fail_count;
    int pending;
    int words_checked;
    int runs_closed;

    // no idling on either side while set
    bit calm = 1'b0;

    // current register values, for shaping calibration runs
    logic [RAW_W-1:0]  cfg_nominal;
    logic [RAW_W-1:0]  cfg_tol;
    logic [CNT_W-1:0]  cfg_len;
    logic [GAIN_W-1:0] cfg_gain;

    int words_sent;
    int polls_sent;
    int settings;
    int phase_no;

    phase_current_offset_calibrate_scale_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    phase_current_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .runs_closed   (runs_closed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 30);
    end

    // run limit
    initial begin
        #10_000_000;
        $display("run timed out with %0d result words outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [RAW_W-1:0] to_code(input int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return RAW_W'(4095);
        return v[RAW_W-1:0];
    endfunction

    function automatic logic [RAW_W-1:0] near(input logic [RAW_W-1:0] center, input int spread);
        return to_code(int'(center) + int'($urandom_range(2 * spread)) - spread);
    endfunction

    // per-phase target code: inside tolerance, at or just past its edge, or anywhere
    function automatic logic [RAW_W-1:0] pick_aim();
        int t;
        int e;
        t = int'(cfg_tol);
        case ($urandom_range(3))
            0, 1: return near(cfg_nominal, t);
            2: begin
                e = t + int'($urandom_range(1));
                if ($urandom_range(1) == 1)
                    e = -e;
                return to_code(int'(cfg_nominal) + e);
            end
            default: return RAW_W'($urandom_range(4095));
        endcase
    endfunction

    task automatic send_word(input logic act, input logic ok, input logic [RAW_W-1:0] a,
                             input logic [RAW_W-1:0] b, input logic [RAW_W-1:0] c);
        int gap;
        if (!calm && $urandom_range(99) < 30) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = S_DATA_W'({c, b, a});
        s_tuser  = {ok, act};
        do
            @(posedge aclk);
        while (!s_tready);
        words_sent++;
        if (act == ACT_POLL)
            polls_sent++;
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // wait until the block is idle, then rewrite all four registers
    task automatic configure(input logic [RAW_W-1:0] nominal, input logic [RAW_W-1:0] tol,
                             input logic [CNT_W-1:0] len, input logic [GAIN_W-1:0] g);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        write_reg(REG_DEFAULT_OFFSET, CFG_D_W'(nominal));
        write_reg(REG_FAULT_TOLERANCE, CFG_D_W'(tol));
        write_reg(REG_CAL_SAMPLES, len);
        write_reg(REG_AMP_GAIN, g);
        cfg_nominal = nominal;
        cfg_tol     = tol;
        cfg_len     = len;
        cfg_gain    = g;
        settings++;
    endtask

    // one full run of polls around chosen targets, with measures mixed in
    task automatic calibration_run();
        logic [RAW_W-1:0] aim [NPHASE];
        int               n;
        int               k;
        int               jit;
        n = (cfg_len == '0) ? 1 : int'(cfg_len);
        jit = ($urandom_range(1) == 1) ? 3 : 0;
        aim[0] = pick_aim();
        aim[1] = pick_aim();
        aim[2] = pick_aim();
        for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 25)
                send_word(ACT_MEASURE, 1'($urandom_range(1)), near(aim[0], 40),
                          near(aim[1], 40), near(aim[2], 40));
            send_word(ACT_POLL, $urandom_range(99) < 85, near(aim[0], jit),
                      near(aim[1], jit), near(aim[2], jit));
        end
    endtask

    task automatic random_phase(input int idx);
        logic [RAW_W-1:0]  nom;
        logic [RAW_W-1:0]  tol;
        logic [CNT_W-1:0]  len;
        logic [GAIN_W-1:0] g;
        int                r;
        int                budget;
        r = $urandom_range(99);
        nom = (r < 20) ? RAW_W'(0) : (r < 40) ? RAW_W'(4095) :
              (r < 60) ? RAW_W'(2048) : RAW_W'($urandom_range(4095));
        r = $urandom_range(99);
        tol = (r < 15) ? RAW_W'(0) : (r < 30) ? RAW_W'(4095) : RAW_W'($urandom_range(400));
        r = $urandom_range(99);
        len = (r < 10) ? CNT_W'(0) : (r < 90) ? CNT_W'($urandom_range(1, 8)) :
              CNT_W'($urandom_range(9, 24));
        r = $urandom_range(99);
        g = (r < 15) ? GAIN_W'(0) : (r < 30) ? GAIN_W'(65535) :
            (r < 50) ? GAIN_W'(256) : GAIN_W'($urandom_range(65535));
        configure(nom, tol, len, g);
        calm = (idx >= 5 && idx < 8);
        budget = words_sent + $urandom_range(40, 60);
        while (words_sent < budget) begin
            r = $urandom_range(99);
            if (r < 55)
                calibration_run();
            else if (r < 85)
                send_word(ACT_MEASURE, 1'($urandom_range(1)), RAW_W'($urandom_range(4095)),
                          RAW_W'($urandom_range(4095)), RAW_W'($urandom_range(4095)));
            else
                send_word(ACT_POLL, 1'($urandom_range(1)), RAW_W'($urandom_range(4095)),
                          RAW_W'($urandom_range(4095)), RAW_W'($urandom_range(4095)));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        cfg_nominal = RST_DEFAULT_OFFSET;
        cfg_tol     = RST_FAULT_TOLERANCE;
        cfg_len     = RST_CAL_SAMPLES;
        cfg_gain    = RST_AMP_GAIN;
        words_sent  = 0;
        polls_sent  = 0;
        settings    = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset defaults: unit gain around mid-scale
        send_word(ACT_MEASURE, 1'b0, 12'd0, 12'd4095, 12'd2048);
        send_word(ACT_MEASURE, 1'b1, 12'd4095, 12'd0, 12'd2047);
        send_word(ACT_MEASURE, 1'b0, 12'd2049, 12'd1, 12'd4094);

        // single-poll runs (zero length), full gain, tolerance edge
        configure(12'd2048, 12'd200, 16'd0, 16'd65535);
        send_word(ACT_POLL, 1'b1, 12'd2053, 12'd2041, 12'd2248);
        send_word(ACT_POLL, 1'b0, 12'd0, 12'd0, 12'd0);
        send_word(ACT_MEASURE, 1'b0, 12'd0, 12'd4095, 12'd2048);
        send_word(ACT_POLL, 1'b1, 12'd2249, 12'd1847, 12'd2048);
        // run with no good poll keeps offsets and fault bits
        send_word(ACT_POLL, 1'b0, 12'd4095, 12'd4095, 12'd4095);
        send_word(ACT_MEASURE, 1'b1, 12'd4095, 12'd0, 12'd1);

        // calibrate offsets down to zero, measure mid-run, largest positive current
        configure(12'd0, 12'd4095, 16'd3, 16'd65535);
        send_word(ACT_POLL, 1'b1, 12'd0, 12'd0, 12'd0);
        send_word(ACT_POLL, 1'b0, 12'd4095, 12'd4095, 12'd4095);
        send_word(ACT_MEASURE, 1'b0, 12'd5, 12'd5, 12'd5);
        send_word(ACT_POLL, 1'b1, 12'd0, 12'd0, 12'd0);
        send_word(ACT_MEASURE, 1'b0, 12'd4095, 12'd4095, 12'd4095);

        // offsets up to full scale, largest negative current
        configure(12'd4095, 12'd4095, 16'd1, 16'd65535);
        send_word(ACT_POLL, 1'b1, 12'd4095, 12'd4095, 12'd4095);
        send_word(ACT_MEASURE, 1'b0, 12'd0, 12'd0, 12'd0);
        send_word(ACT_MEASURE, 1'b1, 12'd4095, 12'd2048, 12'd1);

        // longest run, zero gain and zero tolerance, then target lowered mid-run
        configure(12'd2048, 12'd0, 16'd65535, 16'd0);
        send_word(ACT_MEASURE, 1'b0, 12'd0, 12'd4095, 12'd1234);
        send_word(ACT_POLL, 1'b1, 12'd2048, 12'd2048, 12'd2049);
        send_word(ACT_POLL, 1'b1, 12'd2048, 12'd2048, 12'd2049);
        send_word(ACT_POLL, 1'b0, 12'd100, 12'd3000, 12'd7);
        configure(12'd2048, 12'd0, 16'd2, 16'd0);
        send_word(ACT_POLL, 1'b1, 12'd2048, 12'd2048, 12'd2050);
        send_word(ACT_MEASURE, 1'b0, 12'd2048, 12'd2048, 12'd2048);

        // random settings, mostly well-formed calibration runs
        phase_no = 0;
        while (words_sent < 1050) begin
            random_phase(phase_no);
            phase_no++;
        end
        calm = 1'b0;

        // drain
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (120) @(negedge aclk);

        $display("sent %0d words (%0d calibration polls) under %0d register settings",
                 words_sent, polls_sent, settings);
        $display("checked %0d result words, %0d calibration runs closed, %0d failures",
                 words_checked, runs_closed, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
